FILE: hw/rtl/salwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salwc_pkg
// Shared constants and types of the set-associative LRU write-back cache.
// ----------------------------------------------------------------------------
package salwc_pkg;

    localparam int SETS   = 64;
    localparam int WAYS   = 4;
    localparam int ADDR_W = 32;
    localparam int TAG_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W  = 32;

    // largest usable index width: floor(log2(SETS))
    localparam int MAX_IB = $clog2(SETS + 1) - 1;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int OFFSET_BITS_W = 4;
    localparam int INDEX_BITS_W  = 3;
    localparam int CFG_DATA_W    = 4;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 4'd5;
    localparam logic [INDEX_BITS_W-1:0]  INDEX_BITS_RST  = 3'd6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OFFSET_BITS = 1'b0,
        REG_INDEX_BITS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    // one way of a set row in the line RAM
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
        logic               dirty;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

endpackage
`default_nettype wire

FILE: hw/rtl/salwc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module salwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_lru_writeback_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Tag-only set-associative write-back, write-allocate cache with LRU.
// ----------------------------------------------------------------------------
// Usage:
//   An access (action, address) is taken on a clock edge with start high and
//   busy low. The set row (tag, stamp and dirty bit of every way) is read
//   from the line RAM at that edge; in the next cycle, with busy high, the
//   ways are compared, a victim is picked and the updated row is written back.
//   Valid bits live in flops, cleared by reset.
//   The result beat (hit, writeback and the three running totals) is on the
//   ports for one cycle with done high, the cycle after the lookup cycle.
//   A new access may be started in the cycle that shows done but not while
//   busy is high; the read-then-write of the line RAM sets that limit.
//   The write lands before the next read, so same-set accesses need no
//   forwarding. Results cannot be held off; the receiver takes each beat.
//   Config (offset_bits, index_bits) is to be written through cfg_we/cfg_index/
//   cfg_data only while idle; the block does not enforce this. Reset clears
//   valid, the access counter and the totals; dirty, tag and stamp are only
//   read for valid ways, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              action,
    input  wire logic [salwc_pkg::ADDR_W-1:0]      address,
    input  wire logic                              cfg_we,
    input  wire logic [salwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [salwc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                   done,
    output logic                                   hit,
    output logic                                   writeback,
    output logic [salwc_pkg::CNT_W-1:0]            read_miss_total,
    output logic [salwc_pkg::CNT_W-1:0]            write_miss_total,
    output logic [salwc_pkg::CNT_W-1:0]            writeback_total
);

    salwc_pkg::state_t state_reg, state_next;

    logic [salwc_pkg::OFFSET_BITS_W-1:0] offset_bits_reg;
    logic [salwc_pkg::INDEX_BITS_W-1:0]  index_bits_reg;

    logic [salwc_pkg::SETS-1:0][salwc_pkg::WAYS-1:0] valid_reg;

    logic [salwc_pkg::STAMP_W-1:0] counter_reg;
    logic [salwc_pkg::CNT_W-1:0]   rd_miss_reg, wr_miss_reg, wb_cnt_reg;

    logic [salwc_pkg::SET_W-1:0]   set_reg;
    logic [salwc_pkg::TAG_W-1:0]   tag_reg;
    logic [salwc_pkg::STAMP_W-1:0] stamp_reg;
    logic                          write_reg;
    logic                          done_reg, hit_reg, wb_reg;

    logic                          accept;
    logic [5:0]                    ib_eff;
    logic [5:0]                    tag_shift;
    logic [salwc_pkg::ADDR_W-1:0]  set_mask;
    logic [salwc_pkg::ADDR_W-1:0]  set_full;
    logic [salwc_pkg::SET_W-1:0]   set_next;
    logic [salwc_pkg::TAG_W-1:0]   tag_next;

    salwc_pkg::row_t               row_rd, row_next;
    logic [salwc_pkg::ROW_W-1:0]   ram_rdata;
    logic [salwc_pkg::WAYS-1:0]    vrow;

    logic                          hit_c, empty_c, wb_c;
    logic [salwc_pkg::WAY_W-1:0]   hit_way, empty_way, lru_way, victim;
    logic [salwc_pkg::STAMP_W-1:0] oldest;

    assign busy   = (state_reg == salwc_pkg::ST_LOOKUP);
    assign accept = start && !busy;

    // ---------------- address split ----------------
    always_comb
    begin
        if ({3'b000, index_bits_reg} > 6'(salwc_pkg::MAX_IB))
        begin
            ib_eff = 6'(salwc_pkg::MAX_IB);
        end
        else
        begin
            ib_eff = {3'b000, index_bits_reg};
        end
        tag_shift = {2'b00, offset_bits_reg} + ib_eff;
        set_mask  = (32'd1 << ib_eff) - 32'd1;
        set_full  = (address >> offset_bits_reg) & set_mask;
        set_next  = set_full[salwc_pkg::SET_W-1:0];
        tag_next  = address >> tag_shift;
    end

    // ---------------- line RAM ----------------
    salwc_ram #(
        .WIDTH(salwc_pkg::ROW_W),
        .DEPTH(salwc_pkg::SETS)
    ) u_line_ram (
        .clk  (clk),
        .we   (busy),
        .waddr(set_reg),
        .wdata(row_next),
        .re   (accept),
        .raddr(set_next),
        .rdata(ram_rdata)
    );

    // ---------------- lookup ----------------
    always_comb
    begin
        row_rd = ram_rdata;
        vrow   = valid_reg[set_reg];

        hit_c   = 1'b0;
        hit_way = '0;
        for (int i = 0; i < salwc_pkg::WAYS; i++)
        begin
            if (!hit_c && vrow[i] && row_rd[i].tag == tag_reg)
            begin
                hit_c   = 1'b1;
                hit_way = salwc_pkg::WAY_W'(i);
            end
        end

        empty_c   = 1'b0;
        empty_way = '0;
        for (int i = 0; i < salwc_pkg::WAYS; i++)
        begin
            if (!empty_c && !vrow[i])
            begin
                empty_c   = 1'b1;
                empty_way = salwc_pkg::WAY_W'(i);
            end
        end

        // strict compare keeps the lowest way on ties
        lru_way = '0;
        oldest  = row_rd[0].stamp;
        for (int i = 1; i < salwc_pkg::WAYS; i++)
        begin
            if (row_rd[i].stamp < oldest)
            begin
                oldest  = row_rd[i].stamp;
                lru_way = salwc_pkg::WAY_W'(i);
            end
        end

        if (hit_c)
        begin
            victim = hit_way;
        end
        else if (empty_c)
        begin
            victim = empty_way;
        end
        else
        begin
            victim = lru_way;
        end

        wb_c = !hit_c && !empty_c && row_rd[lru_way].dirty;

        row_next = row_rd;
        row_next[victim].tag   = tag_reg;
        row_next[victim].stamp = stamp_reg;
        row_next[victim].dirty = hit_c ? (row_rd[victim].dirty | write_reg) : write_reg;
    end

    // ---------------- control ----------------
    always_comb
    begin
        case (state_reg)
            salwc_pkg::ST_IDLE:
            begin
                state_next = accept ? salwc_pkg::ST_LOOKUP : salwc_pkg::ST_IDLE;
            end
            salwc_pkg::ST_LOOKUP:
            begin
                state_next = salwc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = salwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= salwc_pkg::ST_IDLE;
            offset_bits_reg <= salwc_pkg::OFFSET_BITS_RST;
            index_bits_reg  <= salwc_pkg::INDEX_BITS_RST;
            valid_reg       <= '0;
            counter_reg     <= '0;
            rd_miss_reg     <= '0;
            wr_miss_reg     <= '0;
            wb_cnt_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= busy;
            if (cfg_we)
            begin
                case (salwc_pkg::cfg_reg_t'(cfg_index))
                    salwc_pkg::REG_OFFSET_BITS:
                    begin
                        offset_bits_reg <= cfg_data[salwc_pkg::OFFSET_BITS_W-1:0];
                    end
                    salwc_pkg::REG_INDEX_BITS:
                    begin
                        index_bits_reg <= cfg_data[salwc_pkg::INDEX_BITS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (busy)
            begin
                valid_reg[set_reg][victim] <= 1'b1;
                if (!hit_c)
                begin
                    if (write_reg)
                    begin
                        wr_miss_reg <= wr_miss_reg + 32'd1;
                    end
                    else
                    begin
                        rd_miss_reg <= rd_miss_reg + 32'd1;
                    end
                end
                if (wb_c)
                begin
                    wb_cnt_reg <= wb_cnt_reg + 32'd1;
                end
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg   <= set_next;
            tag_reg   <= tag_next;
            stamp_reg <= counter_reg;
            write_reg <= action;
        end
        if (busy)
        begin
            hit_reg <= hit_c;
            wb_reg  <= wb_c;
        end
    end

    assign done             = done_reg;
    assign hit              = hit_reg;
    assign writeback        = wb_reg;
    assign read_miss_total  = rd_miss_reg;
    assign write_miss_total = wr_miss_reg;
    assign writeback_total  = wb_cnt_reg;

    // ---------------- assertions ----------------
    a_lookup_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("lookup not followed by a result beat");

    a_hit_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && writeback))
        else $error("writeback reported on a hit");

    a_hit_keeps_misses: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> ($stable(read_miss_total) && $stable(write_miss_total)))
        else $error("miss total moved on a hit");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache testbench
// Drives reads and writes through the start/busy port under a series of
// offset/index geometries. A tag-level cache tracker predicts each done beat
// (hit, writeback, running totals), and the beats are compared in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINES = salwc_pkg::SETS * salwc_pkg::WAYS;

    typedef struct {
        logic                        hit;
        logic                        writeback;
        logic [salwc_pkg::CNT_W-1:0] rd_miss;
        logic [salwc_pkg::CNT_W-1:0] wr_miss;
        logic [salwc_pkg::CNT_W-1:0] wb_count;
    } access_result_t;

    class cache_tracker;
        logic [salwc_pkg::OFFSET_BITS_W-1:0] offset_bits;
        logic [salwc_pkg::INDEX_BITS_W-1:0]  index_bits;
        bit                                  line_valid [LINES];
        bit                                  line_dirty [LINES];
        logic [salwc_pkg::TAG_W-1:0]         line_tag   [LINES];
        logic [salwc_pkg::STAMP_W-1:0]       line_stamp [LINES];
        logic [salwc_pkg::STAMP_W-1:0]       access_count;
        logic [salwc_pkg::CNT_W-1:0]         rd_misses;
        logic [salwc_pkg::CNT_W-1:0]         wr_misses;
        logic [salwc_pkg::CNT_W-1:0]         wb_count;
        access_result_t                      due_results [$];
        int                                  errors;
        int                                  beats;
        int                                  hits;
        int                                  dirty_evictions;

        function new();
            offset_bits = salwc_pkg::OFFSET_BITS_RST;
            index_bits  = salwc_pkg::INDEX_BITS_RST;
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            access_count    = '0;
            rd_misses       = '0;
            wr_misses       = '0;
            wb_count        = '0;
            errors          = 0;
            beats           = 0;
            hits            = 0;
            dirty_evictions = 0;
        endfunction

        function void set_reg(salwc_pkg::cfg_reg_t r, logic [salwc_pkg::CFG_DATA_W-1:0] v);
            case (r)
                salwc_pkg::REG_OFFSET_BITS: offset_bits = v[salwc_pkg::OFFSET_BITS_W-1:0];
                salwc_pkg::REG_INDEX_BITS:  index_bits  = v[salwc_pkg::INDEX_BITS_W-1:0];
                default: ;
            endcase
        endfunction

        // index width actually in use: clamped to log2 of the set count
        function int unsigned set_bits();
            return (index_bits > salwc_pkg::MAX_IB) ? salwc_pkg::MAX_IB : index_bits;
        endfunction

        function void note_access(logic is_write, logic [salwc_pkg::ADDR_W-1:0] addr);
            int unsigned    ib;
            int unsigned    set_no;
            int unsigned    base;
            int unsigned    pick;
            int             w;
            bit             found;
            logic [salwc_pkg::TAG_W-1:0]   tag_v;
            logic [salwc_pkg::STAMP_W-1:0] oldest;
            access_result_t r;
            ib     = set_bits();
            set_no = (addr >> offset_bits) & ((32'd1 << ib) - 32'd1);
            tag_v  = addr >> (offset_bits + ib);
            base   = set_no * salwc_pkg::WAYS;
            found  = 1'b0;
            r.writeback = 1'b0;
            for (w = 0; w < salwc_pkg::WAYS; w++)
            begin
                if (!found && line_valid[base+w] && line_tag[base+w] == tag_v)
                begin
                    found = 1'b1;
                    line_stamp[base+w] = access_count;
                    if (is_write)
                        line_dirty[base+w] = 1'b1;
                end
            end
            if (!found)
            begin
                pick = salwc_pkg::WAYS;
                for (w = 0; w < salwc_pkg::WAYS; w++)
                    if (pick == salwc_pkg::WAYS && !line_valid[base+w])
                        pick = w;
                if (pick == salwc_pkg::WAYS)
                begin
                    // full set: oldest stamp goes, lowest way wins a tie
                    pick   = 0;
                    oldest = line_stamp[base];
                    for (w = 1; w < salwc_pkg::WAYS; w++)
                    begin
                        if (line_stamp[base+w] < oldest)
                        begin
                            oldest = line_stamp[base+w];
                            pick   = w;
                        end
                    end
                    if (line_dirty[base+pick])
                    begin
                        r.writeback = 1'b1;
                        wb_count    = wb_count + 32'd1;
                    end
                end
                line_valid[base+pick] = 1'b1;
                line_tag[base+pick]   = tag_v;
                line_stamp[base+pick] = access_count;
                line_dirty[base+pick] = is_write;
                if (is_write)
                    wr_misses = wr_misses + 32'd1;
                else
                    rd_misses = rd_misses + 32'd1;
            end
            access_count = access_count + 32'd1;
            r.hit      = found;
            r.rd_miss  = rd_misses;
            r.wr_miss  = wr_misses;
            r.wb_count = wb_count;
            due_results.insert(due_results.size(), r);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_beat(logic h, logic wb, logic [salwc_pkg::CNT_W-1:0] rm,
                        logic [salwc_pkg::CNT_W-1:0] wm, logic [salwc_pkg::CNT_W-1:0] wbt);
            access_result_t e;
            if (due_results.size() == 0)
            begin
                report($sformatf("result beat with no access pending (hit=%b)", h));
                return;
            end
            e = due_results.pop_front();
            beats++;
            if (e.hit)
                hits++;
            if (e.writeback)
                dirty_evictions++;
            if (h !== e.hit)
                report($sformatf("beat %0d hit %b, want %b", beats, h, e.hit));
            if (wb !== e.writeback)
                report($sformatf("beat %0d writeback %b, want %b", beats, wb, e.writeback));
            if (rm !== e.rd_miss)
                report($sformatf("beat %0d read_miss_total %0d, want %0d",
                                 beats, rm, e.rd_miss));
            if (wm !== e.wr_miss)
                report($sformatf("beat %0d write_miss_total %0d, want %0d",
                                 beats, wm, e.wr_miss));
            if (wbt !== e.wb_count)
                report($sformatf("beat %0d writeback_total %0d, want %0d",
                                 beats, wbt, e.wb_count));
        endtask

        task finish();
            while (due_results.size() != 0)
            begin
                void'(due_results.pop_front());
                report("access accepted but its result beat never came");
            end
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              action;
    logic [salwc_pkg::ADDR_W-1:0]      address;
    logic                              cfg_we;
    logic [salwc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [salwc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                              done;
    logic                              hit;
    logic                              writeback;
    logic [salwc_pkg::CNT_W-1:0]       read_miss_total;
    logic [salwc_pkg::CNT_W-1:0]       write_miss_total;
    logic [salwc_pkg::CNT_W-1:0]       writeback_total;

    cache_tracker                 sb;
    logic [salwc_pkg::TAG_W-1:0]  tag_pool [6];
    int                           off_seq [8] = '{0, 12, 15, 13, 3, 7, 1, 9};
    int                           idx_seq [8] = '{0, 6, 7, 3, 1, 5, 2, 6};
    int                           geometries;

    set_assoc_lru_writeback_cache dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .address          (address),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .hit              (hit),
        .writeback        (writeback),
        .read_miss_total  (read_miss_total),
        .write_miss_total (write_miss_total),
        .writeback_total  (writeback_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check_beat(hit, writeback, read_miss_total, write_miss_total,
                          writeback_total);

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send(logic is_write, logic [salwc_pkg::ADDR_W-1:0] addr);
        start   <= 1'b1;
        action  <= is_write;
        address <= addr;
        do
            @(posedge clk);
        while (busy);
        sb.note_access(is_write, addr);
        @(negedge clk);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(salwc_pkg::cfg_reg_t r, logic [salwc_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(r, v);
        @(negedge clk);
    endtask

    // under the reset geometry: offset 5, index 6, tag starts at bit 11
    function automatic logic [salwc_pkg::ADDR_W-1:0] line_addr(int unsigned tag_v,
                                                              int unsigned set_no,
                                                              int unsigned ofs);
        return (tag_v << 11) | (set_no << 5) | ofs;
    endfunction

    // mostly a few hot sets and a small tag pool so sets fill and evict
    function automatic logic [salwc_pkg::ADDR_W-1:0] pick_address();
        int unsigned                  ib;
        int unsigned                  sh;
        logic [salwc_pkg::ADDR_W-1:0] set_f;
        logic [salwc_pkg::ADDR_W-1:0] ofs_f;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        ib    = sb.set_bits();
        sh    = sb.offset_bits + ib;
        set_f = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom;
        set_f = (set_f & ((32'd1 << ib) - 32'd1)) << sb.offset_bits;
        ofs_f = $urandom & ((32'd1 << sb.offset_bits) - 32'd1);
        return (tag_pool[$urandom_range(0, 5)] << sh) | set_f | ofs_f;
    endfunction

    initial
    begin
        int burst_left;
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = 1'b0;
        address   = '0;
        cfg_we    = 1'b0;
        cfg_index = salwc_pkg::REG_OFFSET_BITS;
        cfg_data  = '0;
        sb        = new();
        geometries = 1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: fill set 0, LRU refresh, clean and dirty victims, edge addresses
        send(1'b0, 32'h0000_0000);
        send(1'b1, 32'hFFFF_FFFF);
        send(1'b1, line_addr(1, 0, 0));
        send(1'b0, line_addr(2, 0, 4));
        send(1'b0, line_addr(3, 0, 8));
        send(1'b0, line_addr(0, 0, 31));
        pause(1);
        send(1'b0, line_addr(4, 0, 0));
        send(1'b1, line_addr(2, 0, 0));
        send(1'b0, line_addr(5, 0, 0));
        pause(3);
        send(1'b0, line_addr(6, 0, 0));
        send(1'b0, line_addr(7, 0, 0));
        send(1'b1, 32'hFFFF_FFE0);
        send(1'b0, line_addr(32'h1F_FFFF, 0, 0));
        send(1'b1, line_addr(32'h1F_FFFF, 0, 17));
        send(1'b0, 32'h8000_0000);
        send(1'b1, 32'h7FFF_FFFF);
        send(1'b1, line_addr(7, 0, 0));
        send(1'b0, line_addr(9, 0, 0));

        for (int p = 0; p < 10; p++)
        begin
            drain();
            if (p < 8)
            begin
                write_cfg(salwc_pkg::REG_OFFSET_BITS, salwc_pkg::CFG_DATA_W'(off_seq[p]));
                write_cfg(salwc_pkg::REG_INDEX_BITS, salwc_pkg::CFG_DATA_W'(idx_seq[p]));
            end
            else
            begin
                write_cfg(salwc_pkg::REG_OFFSET_BITS,
                          salwc_pkg::CFG_DATA_W'($urandom_range(0, 15)));
                write_cfg(salwc_pkg::REG_INDEX_BITS,
                          salwc_pkg::CFG_DATA_W'($urandom_range(0, 7)));
            end
            geometries++;
            foreach (tag_pool[i])
                tag_pool[i] = $urandom;
            burst_left = $urandom_range(1, 8);
            for (int k = 0; k < 113; k++)
            begin
                if (p == 3 && k == 56)
                    drain();
                send(1'($urandom_range(0, 1)), pick_address());
                burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    pause($urandom_range(1, 7));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 8);
                end
            end
        end

        drain();
        repeat (6) @(negedge clk);
        sb.finish();
        $display("Checked %0d accesses over %0d cache geometries", sb.beats, geometries);
        $display("  %0d hits, %0d dirty evictions, %0d mismatches",
                 sb.hits, sb.dirty_evictions, sb.errors);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not complete");
        $display("testbench failed");
        $finish;
    end

endmodule
